// ----- sv/vq_pkg.sv -----
// Package for the vertex quantizer: register codes, lane and side-band types,
// and the one-bit restoring division step shared by every cell.
// No dependencies.
package vq_pkg;

    localparam int QBITS     = 16;
    localparam int NUM_CELLS = QBITS;
    localparam int NUM_LANES = 5;
    localparam int LANE_U    = 3;
    localparam int LANE_W    = 4;
    localparam int REM_W     = 33;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dvs;
        logic [QBITS-1:0] nq;
    } t_lane;

    typedef t_lane [NUM_LANES-1:0] t_lanes;

    typedef struct packed {
        logic [2:0]       pzero;
        logic [2:0]       psat;
        logic             nzero;
        logic             neg_u;
        logic             neg_w;
        logic [3:0][7:0]  qcol;
        logic [1:0][15:0] qtex;
    } t_side;

    function automatic t_lane div_step(input t_lane l);
        logic [REM_W:0]   t;
        logic [REM_W+1:0] diff;
        t_lane            r;
        t     = {l.rem, l.nq[QBITS-1]};
        diff  = {1'b0, t} - {2'b00, l.dvs};
        r.dvs = l.dvs;
        if (!diff[REM_W+1]) begin
            r.rem = diff[REM_W-1:0];
            r.nq  = {l.nq[QBITS-2:0], 1'b1};
        end else begin
            r.rem = t[REM_W-1:0];
            r.nq  = {l.nq[QBITS-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- sv/vq_prep.sv -----
// Front stage of the vertex quantizer: box differences, division operands,
// special-case flags and the color and texture results, registered.
// Depends on vq_pkg.
module vq_prep (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0][31:0]         i_box_lo,
    input  logic [2:0][31:0]         i_box_hi,
    input  logic [2:0][31:0]         i_pos,
    input  logic [2:0][15:0]         i_norm,
    input  logic [3:0][16:0]         i_col,
    input  logic [1:0][16:0]         i_tex,
    output logic                     o_valid,
    input  logic                     i_ready,
    output vq_pkg::t_lanes           o_lanes,
    output vq_pkg::t_side            o_side
);
    import vq_pkg::*;

    logic              r_valid;
    t_lanes            r_lanes;
    t_side             r_side;
    t_lanes            n_lanes;
    t_side             n_side;
    logic signed [32:0] rng [3];
    logic signed [32:0] dd  [3];
    logic [48:0]       num [3];
    logic [2:0][16:0]  ext;
    logic [2:0][16:0]  mag;
    logic [16:0]       s;
    logic [16:0]       ma;
    logic [16:0]       mb;
    logic [31:0]       nma;
    logic [31:0]       nmb;
    logic [25:0]       cp  [4];
    logic [33:0]       tp  [2];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rng[a] = $signed({i_box_hi[a][31], i_box_hi[a]})
                   - $signed({i_box_lo[a][31], i_box_lo[a]});
            dd[a]  = $signed({i_pos[a][31], i_pos[a]})
                   - $signed({i_box_lo[a][31], i_box_lo[a]});
            n_side.pzero[a] = rng[a][32] || (rng[a] == 33'sd0)
                           || dd[a][32] || (dd[a] == 33'sd0);
            n_side.psat[a]  = !n_side.pzero[a] && (dd[a] >= rng[a]);
            num[a] = {dd[a][31:0], 17'b0} - {16'b0, dd[a][31:0], 1'b0}
                   + {17'b0, rng[a][31:0]};
            n_lanes[a].rem = num[a][48:16];
            n_lanes[a].nq  = num[a][15:0];
            n_lanes[a].dvs = {rng[a][31:0], 1'b0};
        end
        for (int k = 0; k < 3; k++) begin
            ext[k] = {i_norm[k][15], i_norm[k]};
            mag[k] = ext[k][16] ? (~ext[k] + 17'd1) : ext[k];
        end
        s  = mag[0] + mag[1] + mag[2];
        ma = i_norm[2][15] ? (s - mag[1]) : mag[0];
        mb = i_norm[2][15] ? (s - mag[0]) : mag[1];
        nma = {ma[16:0], 15'b0} - {15'b0, ma};
        nmb = {mb[16:0], 15'b0} - {15'b0, mb};
        n_lanes[LANE_U].rem = {17'b0, nma[31:16]};
        n_lanes[LANE_U].nq  = nma[15:0];
        n_lanes[LANE_U].dvs = {16'b0, s};
        n_lanes[LANE_W].rem = {17'b0, nmb[31:16]};
        n_lanes[LANE_W].nq  = nmb[15:0];
        n_lanes[LANE_W].dvs = {16'b0, s};
        n_side.nzero = (s == 17'd0);
        n_side.neg_u = i_norm[0][15];
        n_side.neg_w = i_norm[1][15];
        for (int c = 0; c < 4; c++) begin
            cp[c] = {1'b0, i_col[c], 8'b0} - {9'b0, i_col[c]} + 26'd32768;
            n_side.qcol[c] = (cp[c][25:16] > 10'd255) ? 8'hFF : cp[c][23:16];
        end
        for (int t = 0; t < 2; t++) begin
            tp[t] = {1'b0, i_tex[t], 16'b0} - {17'b0, i_tex[t]} + 34'd32768;
            n_side.qtex[t] = (tp[t][33:16] > 18'd65535) ? 16'hFFFF : tp[t][31:16];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lanes <= n_lanes;
            r_side  <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;
    assign o_side  = r_side;

endmodule

// ----- sv/vq_cell.sv -----
// One cell of the division chain: takes one quotient bit per lane and hands
// the lanes and side-band fields to its neighbor. Depends on vq_pkg.
module vq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vq_pkg::t_lanes  i_lanes,
    input  vq_pkg::t_side   i_side,
    output logic            o_valid,
    input  logic            i_ready,
    output vq_pkg::t_lanes  o_lanes,
    output vq_pkg::t_side   o_side
);
    import vq_pkg::*;

    logic   r_valid;
    t_lanes r_lanes;
    t_side  r_side;
    t_lanes n_lanes;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_lanes[l] = div_step(i_lanes[l]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lanes <= n_lanes;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;
    assign o_side  = r_side;

endmodule

// ----- sv/vertex_quantizer_core.sv -----
// Top level of the vertex quantizer: box registers, front stage, the chain
// of division cells and the final result selection. Depends on vq_pkg,
// vq_prep and vq_cell.
//
// One vertex enters per transaction on the input channel (i_valid/o_ready)
// and one quantized vertex leaves per transaction on the output channel
// (o_valid/i_ready). The box corners are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while the block
// is idle, as the block does not enforce it. Unknown indexes are ignored.
// One front stage is followed by sixteen cells that each resolve one
// quotient bit of the three position and two normal divisions. Throughput
// is one vertex per cycle without a stall; every stage has its own valid bit.
// When the receiver stalls, the last cell holds its result and the stages
// behind it keep filling until each holds a vertex, so the pipeline holds
// 17 vertices when o_ready falls.
// Synchronous reset empties every stage and clears the box to zero.
module vertex_quantizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [15:0] i_norm_x,
    input  logic [15:0] i_norm_y,
    input  logic [15:0] i_norm_z,
    input  logic [16:0] i_col_red,
    input  logic [16:0] i_col_green,
    input  logic [16:0] i_col_blue,
    input  logic [16:0] i_col_alpha,
    input  logic [16:0] i_tex_u,
    input  logic [16:0] i_tex_v,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_qpos_x,
    output logic [15:0] o_qpos_y,
    output logic [15:0] o_qpos_z,
    output logic [15:0] o_oct_u,
    output logic [15:0] o_oct_w,
    output logic [7:0]  o_qcol_red,
    output logic [7:0]  o_qcol_green,
    output logic [7:0]  o_qcol_blue,
    output logic [7:0]  o_qcol_alpha,
    output logic [15:0] o_qtex_u,
    output logic [15:0] o_qtex_v
);
    import vq_pkg::*;

    logic [2:0][31:0] r_box_lo;
    logic [2:0][31:0] r_box_hi;
    logic             w_valid [NUM_CELLS+1];
    logic             w_ready [NUM_CELLS+1];
    t_lanes           w_lanes [NUM_CELLS+1];
    t_side            w_side  [NUM_CELLS+1];
    t_lanes           fin_lanes;
    t_side            fin_side;
    logic [15:0]      qu;
    logic [15:0]      qw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_lo <= '0;
            r_box_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BOX_MIN_X: r_box_lo[0] <= i_cfg_data;
                REG_BOX_MIN_Y: r_box_lo[1] <= i_cfg_data;
                REG_BOX_MIN_Z: r_box_lo[2] <= i_cfg_data;
                REG_BOX_MAX_X: r_box_hi[0] <= i_cfg_data;
                REG_BOX_MAX_Y: r_box_hi[1] <= i_cfg_data;
                REG_BOX_MAX_Z: r_box_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vq_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_box_lo (r_box_lo),
        .i_box_hi (r_box_hi),
        .i_pos    ({i_pos_z, i_pos_y, i_pos_x}),
        .i_norm   ({i_norm_z, i_norm_y, i_norm_x}),
        .i_col    ({i_col_alpha, i_col_blue, i_col_green, i_col_red}),
        .i_tex    ({i_tex_v, i_tex_u}),
        .o_valid  (w_valid[0]),
        .i_ready  (w_ready[0]),
        .o_lanes  (w_lanes[0]),
        .o_side   (w_side[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        vq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_lanes (w_lanes[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_lanes (w_lanes[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign w_ready[NUM_CELLS] = i_ready;
    assign o_valid   = w_valid[NUM_CELLS];
    assign fin_lanes = w_lanes[NUM_CELLS];
    assign fin_side  = w_side[NUM_CELLS];

    assign o_qpos_x = fin_side.pzero[0] ? 16'h0000 :
                      fin_side.psat[0]  ? 16'hFFFF : fin_lanes[0].nq;
    assign o_qpos_y = fin_side.pzero[1] ? 16'h0000 :
                      fin_side.psat[1]  ? 16'hFFFF : fin_lanes[1].nq;
    assign o_qpos_z = fin_side.pzero[2] ? 16'h0000 :
                      fin_side.psat[2]  ? 16'hFFFF : fin_lanes[2].nq;

    assign qu = fin_lanes[LANE_U].nq;
    assign qw = fin_lanes[LANE_W].nq;
    assign o_oct_u = fin_side.nzero ? 16'h0000 : (fin_side.neg_u ? (~qu + 16'd1) : qu);
    assign o_oct_w = fin_side.nzero ? 16'h0000 : (fin_side.neg_w ? (~qw + 16'd1) : qw);

    assign o_qcol_red   = fin_side.qcol[0];
    assign o_qcol_green = fin_side.qcol[1];
    assign o_qcol_blue  = fin_side.qcol[2];
    assign o_qcol_alpha = fin_side.qcol[3];
    assign o_qtex_u     = fin_side.qtex[0];
    assign o_qtex_v     = fin_side.qtex[1];

endmodule

// ----- sv/vq_checker.sv -----
// Port-level checks for the vertex quantizer and the bind that attaches them.
// Depends on vertex_quantizer_core.
module vq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_oct_u,
    input logic [15:0] o_oct_w
);

    // A result held back by the receiver must not vanish.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // The encoded normal never reaches the most negative code.
    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_oct_u != 16'h8000) && (o_oct_w != 16'h8000))
        else $error("octahedral coordinate out of range");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind vertex_quantizer_core vq_checker u_vq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_oct_u (o_oct_u),
    .o_oct_w (o_oct_w)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for vertex_quantizer_core: streams vertices under random flow control
// and checks each quantized vertex against a scoreboard that predicts the block.
// Depends on vq_pkg and the vertex_quantizer_core RTL.
module tb_top;
    import vq_pkg::*;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [31:0] pos_x, pos_y, pos_z;
        logic [15:0] norm_x, norm_y, norm_z;
        logic [16:0] col_red, col_green, col_blue, col_alpha;
        logic [16:0] tex_u, tex_v;
    } vertex_t;

    typedef struct packed {
        logic [15:0] qpos_x, qpos_y, qpos_z;
        logic [15:0] oct_u, oct_w;
        logic [7:0]  qcol_red, qcol_green, qcol_blue, qcol_alpha;
        logic [15:0] qtex_u, qtex_v;
    } qvertex_t;

    class vertex_scoreboard;
        longint   box_lo[3];
        longint   box_hi[3];
        qvertex_t expected_q[$];
        int       errors;

        function new();
            for (int i = 0; i < 3; i++) begin
                box_lo[i] = 0;
                box_hi[i] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            if (idx < REG_BOX_MAX_X) begin
                box_lo[idx] = longint'($signed(data));
            end else if (idx <= REG_BOX_MAX_Z) begin
                box_hi[idx - REG_BOX_MAX_X] = longint'($signed(data));
            end
        endfunction

        function logic [15:0] box_axis(longint p, longint lo, longint hi);
            longint span;
            longint d;
            span = hi - lo;
            d = p - lo;
            if (span <= 0 || d <= 0) return 16'd0;
            if (d >= span) return 16'hFFFF;
            return 16'((2 * d * 65535 + span) / (2 * span));
        endfunction

        function longint unit_round(longint c, longint scale);
            longint q;
            q = (c * scale + 32768) >>> 16;
            return (q > scale) ? scale : q;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function qvertex_t quantize(vertex_t v);
            qvertex_t r;
            longint nx, ny, nz, s, u, w, mu, mw;
            r.qpos_x = box_axis(longint'($signed(v.pos_x)), box_lo[0], box_hi[0]);
            r.qpos_y = box_axis(longint'($signed(v.pos_y)), box_lo[1], box_hi[1]);
            r.qpos_z = box_axis(longint'($signed(v.pos_z)), box_lo[2], box_hi[2]);
            nx = longint'($signed(v.norm_x));
            ny = longint'($signed(v.norm_y));
            nz = longint'($signed(v.norm_z));
            s = mag(nx) + mag(ny) + mag(nz);
            if (s == 0) begin
                u = 0;
                w = 0;
            end else if (nz >= 0) begin
                u = (mag(nx) * 32767) / s;
                w = (mag(ny) * 32767) / s;
                if (nx < 0) u = -u;
                if (ny < 0) w = -w;
            end else begin
                mu = ((s - mag(ny)) * 32767) / s;
                mw = ((s - mag(nx)) * 32767) / s;
                u = (nx >= 0) ? mu : -mu;
                w = (ny >= 0) ? mw : -mw;
            end
            r.oct_u = 16'(u);
            r.oct_w = 16'(w);
            r.qcol_red   = 8'(unit_round(longint'(v.col_red), 255));
            r.qcol_green = 8'(unit_round(longint'(v.col_green), 255));
            r.qcol_blue  = 8'(unit_round(longint'(v.col_blue), 255));
            r.qcol_alpha = 8'(unit_round(longint'(v.col_alpha), 255));
            r.qtex_u = 16'(unit_round(longint'(v.tex_u), 65535));
            r.qtex_v = 16'(unit_round(longint'(v.tex_v), 65535));
            return r;
        endfunction

        function void note_vertex(vertex_t v);
            expected_q.push_back(quantize(v));
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(qvertex_t got);
            qvertex_t e;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", got, 0);
                return;
            end
            e = expected_q.pop_front();
            if (got.qpos_x !== e.qpos_x) report_mismatch("qpos_x", got.qpos_x, e.qpos_x);
            if (got.qpos_y !== e.qpos_y) report_mismatch("qpos_y", got.qpos_y, e.qpos_y);
            if (got.qpos_z !== e.qpos_z) report_mismatch("qpos_z", got.qpos_z, e.qpos_z);
            if (got.oct_u !== e.oct_u) report_mismatch("oct_u", got.oct_u, e.oct_u);
            if (got.oct_w !== e.oct_w) report_mismatch("oct_w", got.oct_w, e.oct_w);
            if (got.qcol_red !== e.qcol_red)
                report_mismatch("qcol_red", got.qcol_red, e.qcol_red);
            if (got.qcol_green !== e.qcol_green)
                report_mismatch("qcol_green", got.qcol_green, e.qcol_green);
            if (got.qcol_blue !== e.qcol_blue)
                report_mismatch("qcol_blue", got.qcol_blue, e.qcol_blue);
            if (got.qcol_alpha !== e.qcol_alpha)
                report_mismatch("qcol_alpha", got.qcol_alpha, e.qcol_alpha);
            if (got.qtex_u !== e.qtex_u) report_mismatch("qtex_u", got.qtex_u, e.qtex_u);
            if (got.qtex_v !== e.qtex_v) report_mismatch("qtex_v", got.qtex_v, e.qtex_v);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid;
    vertex_t     in_v = '0;
    qvertex_t    out_v;

    vertex_scoreboard sb = new();

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    vertex_quantizer_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pos_x(in_v.pos_x), .i_pos_y(in_v.pos_y), .i_pos_z(in_v.pos_z),
        .i_norm_x(in_v.norm_x), .i_norm_y(in_v.norm_y), .i_norm_z(in_v.norm_z),
        .i_col_red(in_v.col_red), .i_col_green(in_v.col_green),
        .i_col_blue(in_v.col_blue), .i_col_alpha(in_v.col_alpha),
        .i_tex_u(in_v.tex_u), .i_tex_v(in_v.tex_v),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_qpos_x(out_v.qpos_x), .o_qpos_y(out_v.qpos_y), .o_qpos_z(out_v.qpos_z),
        .o_oct_u(out_v.oct_u), .o_oct_w(out_v.oct_w),
        .o_qcol_red(out_v.qcol_red), .o_qcol_green(out_v.qcol_green),
        .o_qcol_blue(out_v.qcol_blue), .o_qcol_alpha(out_v.qcol_alpha),
        .o_qtex_u(out_v.qtex_u), .o_qtex_v(out_v.qtex_v)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_vertex(in_v);
        if (i_rst_n && o_valid && i_ready) sb.check_result(out_v);
    end

    // The receiver alternates between stalling and free-running stretches, and
    // once early in the run holds off long enough for the pipeline to fill.
    int unsigned rx_cycle = 0;
    int unsigned hold_cnt = 0;
    bit          rx_busy = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if ($urandom_range(0, 199) == 0) rx_busy <= ~rx_busy;
            if (rx_cycle == 300) begin
                hold_cnt <= 120;
                i_ready  <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                i_ready  <= 1'b0;
            end else if (rx_busy && $urandom_range(0, 99) < 2) begin
                hold_cnt <= $urandom_range(10, 40);
                i_ready  <= 1'b0;
            end else begin
                i_ready <= !(rx_busy && $urandom_range(0, 99) < 40);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_box(logic [31:0] lo_x, logic [31:0] lo_y, logic [31:0] lo_z,
                           logic [31:0] hi_x, logic [31:0] hi_y, logic [31:0] hi_z);
        write_reg(REG_BOX_MIN_X, lo_x);
        write_reg(REG_BOX_MIN_Y, lo_y);
        write_reg(REG_BOX_MIN_Z, lo_z);
        write_reg(REG_BOX_MAX_X, hi_x);
        write_reg(REG_BOX_MAX_Y, hi_y);
        write_reg(REG_BOX_MAX_Z, hi_z);
        write_reg(REG_SPARE_A, $urandom());
        write_reg(REG_SPARE_B, $urandom());
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_vertex(vertex_t v);
        in_v    <= v;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic sender_gap();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        n = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain(int unsigned limit);
        int unsigned n;
        n = 0;
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0 && n < limit) begin
            @(posedge i_clk);
            n++;
        end
        repeat (24) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_pos(int axis);
        longint span;
        longint p;
        if ($urandom_range(0, 99) < 20) return $urandom();
        span = sb.box_hi[axis] - sb.box_lo[axis];
        if (span <= 0) span = 1 << 20;
        p = sb.box_lo[axis] - span / 16 + (span * $urandom_range(0, 73728)) / 65536;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return 32'(p);
    endfunction

    function automatic logic [16:0] pick_unit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return 17'd65536;
        if (r < 80) return 17'($urandom_range(0, 65535));
        return 17'($urandom());
    endfunction

    function automatic logic [15:0] pick_norm();
        if ($urandom_range(0, 99) < 25) return 16'($urandom());
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        int unsigned r;
        v.pos_x = pick_pos(0);
        v.pos_y = pick_pos(1);
        v.pos_z = pick_pos(2);
        r = $urandom_range(0, 99);
        v.norm_x = pick_norm();
        v.norm_y = pick_norm();
        v.norm_z = pick_norm();
        if (r < 8) begin
            v.norm_x = '0;
            v.norm_y = '0;
            v.norm_z = '0;
        end else if (r < 16) begin
            v.norm_x = '0;
            v.norm_y = '0;
        end
        v.col_red   = pick_unit();
        v.col_green = pick_unit();
        v.col_blue  = pick_unit();
        v.col_alpha = pick_unit();
        v.tex_u     = pick_unit();
        v.tex_v     = pick_unit();
        return v;
    endfunction

    task automatic send_directed();
        vertex_t v;
        logic [15:0] nv[10][3];
        logic [16:0] cv[5];
        nv = '{'{16'h0000, 16'h0000, 16'h0000}, '{16'h8000, 16'h0000, 16'h0000},
               '{16'h0000, 16'h8000, 16'h0000}, '{16'h0000, 16'h0000, 16'h8000},
               '{16'h8000, 16'h8000, 16'h8000}, '{16'h4000, 16'hC000, 16'h0000},
               '{16'h0000, 16'h0000, 16'hC000}, '{16'hC000, 16'h0000, 16'hF000},
               '{16'h7FFF, 16'h7FFF, 16'h8001}, '{16'h0001, 16'hFFFF, 16'hFFFF}};
        cv = '{17'd0, 17'd65536, 17'h1FFFF, 17'd128, 17'd65535};
        for (int i = 0; i < 20; i++) begin
            v = random_vertex();
            v.norm_x = nv[i % 10][0];
            v.norm_y = nv[i % 10][1];
            v.norm_z = nv[i % 10][2];
            v.col_red   = cv[i % 5];
            v.col_green = cv[(i + 1) % 5];
            v.col_blue  = cv[(i + 2) % 5];
            v.col_alpha = cv[(i + 3) % 5];
            v.tex_u     = cv[(i + 4) % 5];
            v.tex_v     = cv[i % 5];
            case (i % 4)
                0: begin
                    v.pos_x = 32'h8000_0000;
                    v.pos_y = 32'h7FFF_FFFF;
                    v.pos_z = 32'h0;
                end
                1: begin
                    v.pos_x = 32'(sb.box_lo[0]);
                    v.pos_y = 32'(sb.box_hi[1]);
                    v.pos_z = 32'(sb.box_hi[2]);
                end
                default: ;
            endcase
            send_vertex(v);
            sender_gap();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        drain(20000);
        set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_directed();
        for (int ph = 0; ph < 8; ph++) begin
            drain(20000);
            case (ph)
                0: set_box(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                           32'h0001_0000, 32'hFFFE_0000, 32'h8000_0000);
                1: set_box(32'h0000_0000, 32'hFFFF_FFFF, 32'h1000_0000,
                           32'h0000_0001, 32'h0000_0002, 32'h1000_0003);
                default: set_box(32'($signed($urandom_range(0, 65536)) - 32768) << 12,
                                 32'h8000_0000 + $urandom_range(0, 1 << 20),
                                 32'($signed($urandom_range(0, 1000)) - 2000) << 16,
                                 32'($urandom_range(1, 65536)) << 12,
                                 32'h7FFF_FFFF - $urandom_range(0, 1 << 20),
                                 32'($urandom_range(0, 3000)) << 16);
            endcase
            for (int i = 0; i < 200; i++) begin
                send_vertex(random_vertex());
                sender_gap();
            end
        end
        drain(20000);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end
endmodule

// ----- vertex_quantizer_core.f -----
sv/vq_pkg.sv
sv/vq_prep.sv
sv/vq_cell.sv
sv/vertex_quantizer_core.sv
sv/vq_checker.sv
dv/tb_top.sv
